>>> rtl/pidis_pkg.sv
`default_nettype none

package pidis_pkg;

  // Field widths fixed by the interface.
  localparam int GAIN_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int LIMIT_W    = 15;
  localparam int RANGE_W    = 20;
  localparam int DRIVE_W    = 32;

  // Internal arithmetic widths.
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int INTEG_W    = RANGE_W + 1;
  localparam int SUM_W      = INTEG_W + 1;
  localparam int P_KP_W     = GAIN_W + ERR_W;
  localparam int P_KD_W     = GAIN_W + DIFF_W;
  localparam int P_KI_W     = GAIN_W + INTEG_W;
  localparam int ACC_W      = P_KI_W + 3;
  localparam int FRAC_W     = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RANGE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP             = 3'd0,
    CFG_KI             = 3'd1,
    CFG_KD             = 3'd2,
    CFG_MEASURE_LIMIT  = 3'd3,
    CFG_INTEGRAL_RANGE = 3'd4
  } cfg_reg_t;

  // One sample as seen by the multiply stage: error terms and the
  // integrator state as it stood before this sample updated it.
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [INTEG_W-1:0] integ;
    logic                      gate;
  } sample_t;

endpackage

`default_nettype wire

>>> rtl/pidis_integrator.sv
`default_nettype none

module pidis_integrator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic signed [pidis_pkg::SAMPLE_W-1:0]  target,
  input  logic signed [pidis_pkg::SAMPLE_W-1:0]  measure,
  input  logic                                   enabled,
  input  logic        [pidis_pkg::LIMIT_W-1:0]   limit,
  input  logic        [pidis_pkg::RANGE_W-1:0]   range,
  output pidis_pkg::sample_t                     smp
);

  logic signed [pidis_pkg::ERR_W-1:0]   prev_r,  prev_nxt;
  logic signed [pidis_pkg::INTEG_W-1:0] sum_r,   sum_nxt;
  logic                                 gate_r,  gate_nxt;

  logic signed [pidis_pkg::ERR_W-1:0]   err;
  logic signed [pidis_pkg::DIFF_W-1:0]  diff;
  logic signed [pidis_pkg::ERR_W-1:0]   meas_x;
  logic signed [pidis_pkg::ERR_W-1:0]   lim_x;
  logic                                 in_window;
  logic signed [pidis_pkg::SUM_W-1:0]   sum_raw;
  logic signed [pidis_pkg::SUM_W-1:0]   rng_x;
  logic signed [pidis_pkg::SUM_W-1:0]   sum_clamped;

  always_comb begin
    err  = $signed({target[pidis_pkg::SAMPLE_W-1], target})
         - $signed({measure[pidis_pkg::SAMPLE_W-1], measure});
    diff = $signed({err[pidis_pkg::ERR_W-1], err})
         - $signed({prev_r[pidis_pkg::ERR_W-1], prev_r});

    meas_x    = $signed({measure[pidis_pkg::SAMPLE_W-1], measure});
    lim_x     = $signed({2'b00, limit});
    in_window = (meas_x <= lim_x) && (meas_x >= -lim_x);

    sum_raw = pidis_pkg::SUM_W'(sum_r) + pidis_pkg::SUM_W'(err);
    rng_x   = $signed({2'b00, range});
    if (sum_raw > rng_x) begin
      sum_clamped = rng_x;
    end else if (sum_raw < -rng_x) begin
      sum_clamped = -rng_x;
    end else begin
      sum_clamped = sum_raw;
    end

    prev_nxt = prev_r;
    sum_nxt  = sum_r;
    gate_nxt = gate_r;
    if (accept) begin
      prev_nxt = err;
      if (enabled) begin
        if (!in_window) begin
          gate_nxt = 1'b0;
        end else begin
          gate_nxt = 1'b1;
          sum_nxt  = sum_clamped[pidis_pkg::INTEG_W-1:0];
        end
      end else begin
        sum_nxt = '0;
      end
    end

    smp.err   = err;
    smp.diff  = diff;
    smp.integ = sum_r;
    smp.gate  = gate_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      sum_r  <= '0;
      gate_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      sum_r  <= sum_nxt;
      gate_r <= gate_nxt;
    end
  end

  // The clamp is symmetric, so the most negative code is never reached.
  a_sum_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r != {1'b1, {(pidis_pkg::INTEG_W-1){1'b0}}})
    else $error("integral reached the most negative code");

  a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !enabled |=> sum_r == '0)
    else $error("disabled sample did not clear the integral");

  a_window_sets_gate: assert property (@(posedge clk) disable iff (!rst_n)
    accept && enabled && in_window |=> gate_r)
    else $error("sample inside the window did not open the gate");

endmodule

`default_nettype wire

>>> rtl/pid_integral_separation_core.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// cfg       in         cfg_we                  cfg_index, cfg_data
// in        in         in_valid / in_ready     in_target, in_measure, in_enabled
// out       out        out_valid / out_ready   out_drive, out_integral_active
//
// One transaction is accepted per cycle while in_ready is high; each yields one result.
// The integrator state updates in the accept cycle, so samples may follow back to back.
// The three gain multiplies share one register stage; the sum, shift and clamp take the next.
// Reset is synchronous, active low; it loads the default gains and limits and
// empties the pipeline. A stalled output holds its result while the earlier
// stages keep filling until every stage is occupied.

module pid_integral_separation_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic        [pidis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [pidis_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [pidis_pkg::SAMPLE_W-1:0]   in_target,
  input  logic signed [pidis_pkg::SAMPLE_W-1:0]   in_measure,
  input  logic                                    in_enabled,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pidis_pkg::DRIVE_W-1:0]    out_drive,
  output logic                                    out_integral_active
);

  // Configuration registers.
  logic signed [pidis_pkg::GAIN_W-1:0]  kp_r;
  logic signed [pidis_pkg::GAIN_W-1:0]  ki_r;
  logic signed [pidis_pkg::GAIN_W-1:0]  kd_r;
  logic        [pidis_pkg::LIMIT_W-1:0] limit_r;
  logic        [pidis_pkg::RANGE_W-1:0] range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      limit_r <= '1;
      range_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pidis_pkg::CFG_KP:             kp_r    <= cfg_data[pidis_pkg::GAIN_W-1:0];
        pidis_pkg::CFG_KI:             ki_r    <= cfg_data[pidis_pkg::GAIN_W-1:0];
        pidis_pkg::CFG_KD:             kd_r    <= cfg_data[pidis_pkg::GAIN_W-1:0];
        pidis_pkg::CFG_MEASURE_LIMIT:  limit_r <= cfg_data[pidis_pkg::LIMIT_W-1:0];
        pidis_pkg::CFG_INTEGRAL_RANGE: range_r <= cfg_data[pidis_pkg::RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: each stage moves when the stage after it is empty or moving.
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_free, s2_free, s1_free, in_acc;

  assign out_free = !out_v_r || out_ready;
  assign s2_free  = !s2_v_r  || out_free;
  assign s1_free  = !s1_v_r  || s2_free;
  assign in_ready = s1_free;
  assign in_acc   = in_valid && s1_free;

  // Error terms and the integrator state; the state advances on acceptance so
  // the very next transaction already sees it.
  pidis_pkg::sample_t smp;

  pidis_integrator u_integrator (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .target  (in_target),
    .measure (in_measure),
    .enabled (in_enabled),
    .limit   (limit_r),
    .range   (range_r),
    .smp     (smp)
  );

  // Stage 1: registered sample.
  pidis_pkg::sample_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= smp;
    end
  end

  // Stage 2: gain products. The integral product is zero when the gate was shut.
  logic signed [pidis_pkg::P_KP_W-1:0] p_kp_r, p_kp_nxt;
  logic signed [pidis_pkg::P_KD_W-1:0] p_kd_r, p_kd_nxt;
  logic signed [pidis_pkg::P_KI_W-1:0] p_ki_r, p_ki_nxt;
  logic                                s2_gate_r;

  always_comb begin
    p_kp_nxt = $signed(kp_r) * $signed(s1_r.err);
    p_kd_nxt = $signed(kd_r) * $signed(s1_r.diff);
    if (s1_r.gate) begin
      p_ki_nxt = $signed(ki_r) * $signed(s1_r.integ);
    end else begin
      p_ki_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_v_r) begin
      p_kp_r    <= p_kp_nxt;
      p_kd_r    <= p_kd_nxt;
      p_ki_r    <= p_ki_nxt;
      s2_gate_r <= s1_r.gate;
    end
  end

  // Stage 3: sum, floor shift out of Q8.8 (arithmetic shift), saturate.
  logic signed [pidis_pkg::ACC_W-1:0]   acc;
  logic signed [pidis_pkg::ACC_W-1:0]   acc_sh;
  logic signed [pidis_pkg::DRIVE_W-1:0] drive_nxt;
  logic                                 fits;
  logic signed [pidis_pkg::DRIVE_W-1:0] drive_r;
  logic                                 active_r;

  always_comb begin
    acc    = pidis_pkg::ACC_W'(p_kp_r) + pidis_pkg::ACC_W'(p_kd_r)
           + pidis_pkg::ACC_W'(p_ki_r);
    acc_sh = acc >>> pidis_pkg::FRAC_W;
    // The value fits when every bit above the drive's sign bit matches it.
    fits   = (acc_sh[pidis_pkg::ACC_W-1:pidis_pkg::DRIVE_W-1] == '0)
          || (acc_sh[pidis_pkg::ACC_W-1:pidis_pkg::DRIVE_W-1] == '1);
    if (fits) begin
      drive_nxt = acc_sh[pidis_pkg::DRIVE_W-1:0];
    end else begin
      drive_nxt = {acc_sh[pidis_pkg::ACC_W-1],
                   {(pidis_pkg::DRIVE_W-1){~acc_sh[pidis_pkg::ACC_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_v_r) begin
      drive_r  <= drive_nxt;
      active_r <= s2_gate_r;
    end
  end

  assign out_valid           = out_v_r;
  assign out_drive           = drive_r;
  assign out_integral_active = active_r;

  a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !s2_free |=> s2_v_r && $stable(p_ki_r) && $stable(p_kp_r))
    else $error("stage 2 lost its products while stalled");

  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_free |=> s1_v_r && $stable(s1_r))
    else $error("stage 1 lost its sample while stalled");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s2_v_r && out_v_r && !out_ready |-> !in_ready)
    else $error("accepted a transaction with the pipeline full");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_v_r && !s1_v_r && !s2_v_r)
    else $error("reset left a stage occupied");

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // Gains are Q8.8, so this is a gain of exactly one.
  localparam int GAIN_ONE = 1 << pidis_pkg::FRAC_W;

  // The saturation bounds of the drive, in 64-bit arithmetic.
  localparam longint DRIVE_MAX = (64'sd1 <<< (pidis_pkg::DRIVE_W - 1)) - 1;
  localparam longint DRIVE_MIN = -(64'sd1 <<< (pidis_pkg::DRIVE_W - 1));

  // Register extremes.
  localparam int GAIN_MAX  = (1 << (pidis_pkg::GAIN_W - 1)) - 1;
  localparam int GAIN_MIN  = -(1 << (pidis_pkg::GAIN_W - 1));
  localparam int LIMIT_MAX = (1 << pidis_pkg::LIMIT_W) - 1;
  localparam int RANGE_MAX = (1 << pidis_pkg::RANGE_W) - 1;

  // Sample extremes.
  localparam int SAMPLE_MAX = (1 << (pidis_pkg::SAMPLE_W - 1)) - 1;
  localparam int SAMPLE_MIN = -(1 << (pidis_pkg::SAMPLE_W - 1));

  // One result of the controller: the saturated drive and the gate flag
  // that decided whether the integral term took part in it.
  typedef struct {
    logic signed [pidis_pkg::DRIVE_W-1:0] drive;
    logic                                 active;
  } pid_result_t;

  logic                                   clk = 1'b0;
  logic                                   rst_n;
  logic                                   cfg_we;
  logic [pidis_pkg::CFG_IDX_W-1:0]        cfg_index;
  logic [pidis_pkg::CFG_DATA_W-1:0]       cfg_data;
  logic                                   in_valid;
  logic                                   in_ready;
  logic signed [pidis_pkg::SAMPLE_W-1:0]  in_target;
  logic signed [pidis_pkg::SAMPLE_W-1:0]  in_measure;
  logic                                   in_enabled;
  logic                                   out_valid;
  logic                                   out_ready;
  logic signed [pidis_pkg::DRIVE_W-1:0]   out_drive;
  logic                                   out_integral_active;

  // Our own copy of the controller: the register file as last written and
  // the integrator state as the block should hold it after every accepted
  // transaction.
  logic signed [pidis_pkg::GAIN_W-1:0] kp_gain;
  logic signed [pidis_pkg::GAIN_W-1:0] ki_gain;
  logic signed [pidis_pkg::GAIN_W-1:0] kd_gain;
  int                                  window_limit;
  int                                  clamp_range;
  int                                  last_error;
  int                                  integ_sum;
  logic                                integ_gate;

  // Drives that the block owes us, oldest first.
  pid_result_t pending_drives[$];

  int fail_count = 0;

  // While set, neither the sender nor the receiver inserts idle cycles.
  bit no_idle;

  pid_integral_separation_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_target           (in_target),
    .in_measure          (in_measure),
    .in_enabled          (in_enabled),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_drive           (out_drive),
    .out_integral_active (out_integral_active)
  );

  always #4 clk = ~clk;

  // The receiver stalls in about a quarter of the cycles. The new value is
  // set at the falling edge so that it is stable at the next rising edge.
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 24);
  end

  // Runs one PID step on our copy of the state and returns the result that
  // the block must produce for it. The drive is formed from the state as it
  // stood before this sample, then the integrator is updated.
  function automatic pid_result_t compute_drive(
      input logic signed [pidis_pkg::SAMPLE_W-1:0] target,
      input logic signed [pidis_pkg::SAMPLE_W-1:0] measure,
      input logic enabled);
    int          meas;
    int          err;
    int          diff;
    int          sum;
    longint      acc;
    pid_result_t res;
    meas = int'(measure);
    err  = int'(target) - meas;
    diff = err - last_error;
    acc  = longint'(kp_gain) * err + longint'(kd_gain) * diff;
    if (integ_gate) begin
      acc += longint'(ki_gain) * integ_sum;
    end
    // An arithmetic shift of a signed value rounds toward minus infinity,
    // which is what a Q8.8 gain calls for.
    acc = acc >>> pidis_pkg::FRAC_W;
    if (acc > DRIVE_MAX) begin
      acc = DRIVE_MAX;
    end else if (acc < DRIVE_MIN) begin
      acc = DRIVE_MIN;
    end
    res.drive  = acc[pidis_pkg::DRIVE_W-1:0];
    res.active = integ_gate;

    if (enabled) begin
      if (meas > window_limit || meas < -window_limit) begin
        // Measurement outside the window: stop integrating, keep the sum.
        integ_gate = 1'b0;
      end else begin
        sum        = integ_sum + err;
        integ_gate = 1'b1;
        if (sum > clamp_range) begin
          sum = clamp_range;
        end else if (sum < -clamp_range) begin
          sum = -clamp_range;
        end
        integ_sum = sum;
      end
    end else begin
      // Disabled: the integral is dropped but the gate keeps its value.
      integ_sum = 0;
    end
    last_error = err;
    return res;
  endfunction

  // Every result is compared with the oldest drive still owed. Values are
  // read right after the rising edge, so they are the ones the edge saw.
  always @(posedge clk) begin
    pid_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $error("result transaction with no sample pending: drive %0d", out_drive);
        fail_count++;
      end else begin
        want = pending_drives.pop_front();
        if (out_drive !== want.drive) begin
          $error("out_drive: expected %0d, got %0d", want.drive, out_drive);
          fail_count++;
        end
        if (out_integral_active !== want.active) begin
          $error("out_integral_active: expected %0b, got %0b", want.active,
                 out_integral_active);
          fail_count++;
        end
      end
    end
  end

  // Offers one sample and returns at the edge where it is accepted. With
  // idling allowed, valid is dropped for a random number of cycles first.
  // Valid stays high after acceptance; the next call either keeps it high
  // with a new payload or a drain lowers it.
  task automatic send_sample(input logic signed [pidis_pkg::SAMPLE_W-1:0] target,
                             input logic signed [pidis_pkg::SAMPLE_W-1:0] measure,
                             input logic enabled);
    while (!no_idle && $urandom_range(0, 99) < 24) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_target  = target;
    in_measure = measure;
    in_enabled = enabled;
    do begin
      @(posedge clk);
    end while (!in_ready);
    pending_drives.push_back(compute_drive(target, measure, enabled));
  endtask

  // Stops offering samples and waits until every owed result has arrived,
  // then lets the pipeline settle.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_drives.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Registers are only written with the block idle, so every write drains
  // the pipeline first.
  task automatic write_register(input logic [pidis_pkg::CFG_IDX_W-1:0] idx,
                                input logic [pidis_pkg::CFG_DATA_W-1:0] data);
    wait_for_drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      pidis_pkg::CFG_KP:             kp_gain = data[pidis_pkg::GAIN_W-1:0];
      pidis_pkg::CFG_KI:             ki_gain = data[pidis_pkg::GAIN_W-1:0];
      pidis_pkg::CFG_KD:             kd_gain = data[pidis_pkg::GAIN_W-1:0];
      pidis_pkg::CFG_MEASURE_LIMIT:  window_limit = int'(data[pidis_pkg::LIMIT_W-1:0]);
      pidis_pkg::CFG_INTEGRAL_RANGE: clamp_range = int'(data[pidis_pkg::RANGE_W-1:0]);
      default: ;
    endcase
  endtask

  // With all gains at their reset value of zero the drive is zero, but the
  // gate flag still follows the default window, which excludes only the
  // most negative measurement.
  task automatic test_reset_defaults();
    send_sample(16'sd0, 16'sd0, 1'b1);
    send_sample(16'sd100, 16'sd50, 1'b1);
    send_sample(16'sd0, 16'(SAMPLE_MIN), 1'b1);
    send_sample(16'sd0, 16'sd0, 1'b0);
  endtask

  // A tiny negative sum must round down rather than toward zero, and the
  // largest gains of both signs must pass through the full product widths.
  task automatic test_floor_and_gain_extremes();
    write_register(pidis_pkg::CFG_KP, 20'd1);
    write_register(pidis_pkg::CFG_KI, 20'd0);
    write_register(pidis_pkg::CFG_KD, 20'd0);
    send_sample(16'sd0, 16'sd1, 1'b1);

    write_register(pidis_pkg::CFG_KP, 20'(GAIN_MAX));
    write_register(pidis_pkg::CFG_KI, 20'(GAIN_MAX));
    write_register(pidis_pkg::CFG_KD, 20'(GAIN_MAX));
    send_sample(16'(SAMPLE_MAX), 16'(SAMPLE_MIN), 1'b1);
    send_sample(16'(SAMPLE_MIN), 16'(SAMPLE_MAX), 1'b1);

    write_register(pidis_pkg::CFG_KP, 20'(GAIN_MIN));
    write_register(pidis_pkg::CFG_KI, 20'(GAIN_MIN));
    write_register(pidis_pkg::CFG_KD, 20'(GAIN_MIN));
    send_sample(16'(SAMPLE_MAX), 16'(SAMPLE_MIN), 1'b1);
    send_sample(16'(SAMPLE_MIN), 16'(SAMPLE_MAX), 1'b1);
    send_sample(16'sd0, 16'sd0, 1'b1);
  endtask

  // The window edges: a zero limit admits only a zero measurement, and the
  // widest limit still rejects the most negative sample.
  task automatic test_measure_window();
    write_register(pidis_pkg::CFG_MEASURE_LIMIT, 20'd0);
    send_sample(16'sd5, 16'sd0, 1'b1);
    send_sample(16'sd5, 16'sd1, 1'b1);
    send_sample(16'sd5, -16'sd1, 1'b1);

    write_register(pidis_pkg::CFG_MEASURE_LIMIT, 20'(LIMIT_MAX));
    send_sample(16'sd0, 16'(SAMPLE_MAX), 1'b1);
    send_sample(16'sd0, -16'(SAMPLE_MAX), 1'b1);
    send_sample(16'sd0, 16'(SAMPLE_MIN), 1'b1);
  endtask

  // Lowering the clamp below the stored integral must not touch the sum
  // until the next step that actually integrates.
  task automatic test_range_lowered();
    write_register(pidis_pkg::CFG_KP, 20'd0);
    write_register(pidis_pkg::CFG_KD, 20'd0);
    write_register(pidis_pkg::CFG_KI, 20'(GAIN_ONE));
    write_register(pidis_pkg::CFG_INTEGRAL_RANGE, 20'(RANGE_MAX));
    write_register(pidis_pkg::CFG_MEASURE_LIMIT, 20'd1000);
    repeat (3) send_sample(16'sd1000, 16'sd0, 1'b1);

    write_register(pidis_pkg::CFG_INTEGRAL_RANGE, 20'd100);
    send_sample(16'sd0, 16'sd2000, 1'b1);
    send_sample(16'sd0, -16'sd2000, 1'b1);
    send_sample(16'sd10, 16'sd0, 1'b1);
    send_sample(16'sd0, 16'sd0, 1'b1);

    write_register(pidis_pkg::CFG_INTEGRAL_RANGE, 20'd0);
    send_sample(-16'sd5, 16'sd0, 1'b1);
    send_sample(16'sd0, 16'sd0, 1'b0);
  endtask

  // Writes to indexes past the last register must change nothing.
  task automatic test_ignored_index();
    for (int i = int'(pidis_pkg::CFG_INTEGRAL_RANGE) + 1; i < (1 << pidis_pkg::CFG_IDX_W);
         i++) begin
      write_register(i[pidis_pkg::CFG_IDX_W-1:0], 20'($urandom));
    end
    send_sample(16'sd300, -16'sd200, 1'b1);
    send_sample(-16'sd300, 16'sd200, 1'b1);
  endtask

  // One phase of random traffic under one register setting. Setting zero
  // puts every register at its top, setting one at its bottom, any other
  // setting draws each register at random. Most samples follow a slowly
  // moving set point inside the window so that the integral builds up and
  // hits its clamp; the rest leave the window, disable the integrator or
  // are plain noise over the whole field range.
  task automatic test_random_phase(input int items, input bit steady, input int setting);
    int   bias;
    int   span;
    int   run_left;
    int   t;
    int   m;
    int   mag;
    int   pick;
    logic en;
    logic [pidis_pkg::CFG_DATA_W-1:0] gain_data [3];
    logic [pidis_pkg::CFG_DATA_W-1:0] limit_data;
    logic [pidis_pkg::CFG_DATA_W-1:0] range_data;

    for (int g = 0; g < 3; g++) begin
      case ($urandom_range(0, 3))
        0: gain_data[g] = 20'($urandom);
        1: gain_data[g] = 20'(int'($urandom_range(0, 1024)) - 512);
        2: gain_data[g] = $urandom_range(0, 1) ? 20'(GAIN_MAX) : 20'(GAIN_MIN);
        default: gain_data[g] = $urandom_range(0, 1) ? 20'(GAIN_ONE) : 20'd0;
      endcase
      // The bits above the gain width are don't-care and get random values.
      gain_data[g][pidis_pkg::CFG_DATA_W-1:pidis_pkg::GAIN_W] = 4'($urandom);
    end
    case ($urandom_range(0, 3))
      0: limit_data = 20'd0;
      1: limit_data = 20'($urandom_range(1, 64));
      2: limit_data = 20'($urandom);
      default: limit_data = 20'(LIMIT_MAX);
    endcase
    limit_data[pidis_pkg::CFG_DATA_W-1:pidis_pkg::LIMIT_W] = 5'($urandom);
    case ($urandom_range(0, 3))
      0: range_data = 20'd0;
      1: range_data = 20'($urandom_range(1, 2000));
      2: range_data = 20'($urandom);
      default: range_data = 20'(RANGE_MAX);
    endcase

    if (setting == 0) begin
      gain_data  = '{20'(GAIN_MAX), 20'(GAIN_MAX), 20'(GAIN_MAX)};
      limit_data = 20'(LIMIT_MAX);
      range_data = 20'(RANGE_MAX);
    end else if (setting == 1) begin
      gain_data  = '{20'(GAIN_MIN), 20'(GAIN_MIN), 20'(GAIN_MIN)};
      limit_data = 20'd0;
      range_data = 20'd0;
    end

    write_register(pidis_pkg::CFG_KP, gain_data[0]);
    write_register(pidis_pkg::CFG_KI, gain_data[1]);
    write_register(pidis_pkg::CFG_KD, gain_data[2]);
    write_register(pidis_pkg::CFG_MEASURE_LIMIT, limit_data);
    write_register(pidis_pkg::CFG_INTEGRAL_RANGE, range_data);

    no_idle  = steady;
    run_left = 0;
    bias     = 0;
    for (int n = 0; n < items; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 40);
        span     = 1 << $urandom_range(0, 14);
        bias     = $urandom_range(0, span);
        if ($urandom_range(0, 1)) begin
          bias = -bias;
        end
      end
      run_left--;

      pick = $urandom_range(0, 99);
      m    = int'($urandom_range(0, 2 * window_limit)) - window_limit;
      t    = m + bias + int'($urandom_range(0, 6)) - 3;
      en   = 1'b1;
      if (pick < 60) begin
        // Tracking a set point inside the window.
      end else if (pick < 72) begin
        if (window_limit >= SAMPLE_MAX || $urandom_range(0, 7) == 0) begin
          m = SAMPLE_MIN;
        end else begin
          mag = $urandom_range(window_limit + 1, SAMPLE_MAX);
          m   = $urandom_range(0, 1) ? mag : -mag;
        end
      end else if (pick < 87) begin
        t  = $urandom;
        m  = $urandom;
        en = 1'($urandom_range(0, 1));
      end else begin
        en = 1'b0;
      end
      send_sample(t[pidis_pkg::SAMPLE_W-1:0], m[pidis_pkg::SAMPLE_W-1:0], en);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_target  = '0;
    in_measure = '0;
    in_enabled = 1'b0;
    no_idle    = 1'b0;

    // Reset values of the registers and the integrator.
    kp_gain      = '0;
    ki_gain      = '0;
    kd_gain      = '0;
    window_limit = LIMIT_MAX;
    clamp_range  = RANGE_MAX;
    last_error   = 0;
    integ_sum    = 0;
    integ_gate   = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_floor_and_gain_extremes();
    test_measure_window();
    test_range_lowered();
    test_ignored_index();

    // Each phase starts with a full drain, so the sender waits for every
    // owed result several times. Phase four runs without any idle cycles.
    for (int p = 0; p < 8; p++) begin
      test_random_phase(180, p == 4, p);
    end

    wait_for_drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[pid_integral_separation_core] OK");
    end else begin
      $display("[pid_integral_separation_core] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #3000000;
    $display("[pid_integral_separation_core] ERROR");
    $finish;
  end

endmodule
